/* rtl/grl_pkg.sv */
// ----------------------------------------------------------------------------
// grl_pkg
// Shared widths, codes and helpers of the gyro rate loop with yaw PID.
// ----------------------------------------------------------------------------
package grl_pkg;

  localparam int STICK_W = 12;
  localparam int RATE_W  = 10;
  localparam int DELTA_W = RATE_W + 1;
  localparam int GAIN_W  = 8;
  localparam int MCAND_W = 32;
  localparam int PROD_W  = MCAND_W + GAIN_W;
  localparam int YPROD_W = DELTA_W + GAIN_W;
  localparam int ERR_W   = 18;
  localparam int THR_W   = 13;
  localparam int IMAX_W  = 12;
  localparam int OUT_W   = 16;
  localparam int CNT_W   = 3;

  localparam logic signed [PROD_W-1:0] EMAX = PROD_W'(132000);
  localparam int PID_SHIFT = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GYRO,
    S_SCALE,
    S_LOAD,
    S_PID,
    S_CLAMP,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    REG_RP_GAIN,
    REG_RP_SHIFT,
    REG_YAW_GAIN,
    REG_YAW_SHIFT,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_REVERSE,
    REG_THR_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_ARM     = 3'd1,
    CMD_DISARM  = 3'd2,
    CMD_GYRO_CAL = 3'd3,
    CMD_ACC_CAL = 3'd4
  } cmd_t;

  // floor shift of the gain product, wrap to 16, optional negate
  function automatic logic [OUT_W-1:0] scale_gyro(input logic signed [PROD_W-1:0] p,
                                                  input logic [3:0] sh,
                                                  input logic rev);
    logic signed [PROD_W-1:0] s;
    logic [OUT_W-1:0] g;
    s = p >>> sh;
    g = s[OUT_W-1:0];
    if (rev) begin
      g = OUT_W'(-g);
    end
    return g;
  endfunction

endpackage

/* rtl/gyro_rate_loop_with_yaw_pid_unit.sv */
// ----------------------------------------------------------------------------
// gyro_rate_loop_with_yaw_pid_unit
// Multirotor rate loop: gyro damping on roll/pitch, clamped yaw PID, arming.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------
//  s_*     | in  | s_tvalid / s_tready     | s_tdata: one control tick
//  m_*     | out | m_tvalid / m_tready     | m_tdata: mixer inputs + motors_off
//  cfg_*   | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data: gain regs
//
//  A tick runs a gyro pass through three bit-serial multipliers (gyro gains),
//  then a PID pass through two of them (P and I gains), plus states for
//  scaling, setup, clamping and summing before the next tick is accepted.
//  rst (synchronous) restores register defaults, disarms, clears integral.
//  A result waits in the output register while the next tick is accepted;
//  only the final write stalls if that register is still full.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module gyro_rate_loop_with_yaw_pid_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [11:0] stick_roll, [23:12] stick_pitch, [35:24] stick_yaw,
  // [47:36] stick_throttle, [57:48] rate_roll, [67:58] rate_pitch,
  // [77:68] rate_yaw, [87:78] zero_roll, [97:88] zero_pitch,
  // [107:98] zero_yaw, [110:108] command, [111] zero
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [12:0] throttle_out, [28:13] roll_out, [44:29] pitch_out,
  // [60:45] yaw_out, [61] motors_off, [63:62] zero
  output logic [63:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [10:0]  cfg_data
);
  import grl_pkg::*;

  // configuration
  logic [GAIN_W-1:0] rp_gain, yaw_gain, prop_gain, integ_gain;
  logic [3:0]        rp_shift, yaw_shift;
  logic [2:0]        reverse;
  logic [10:0]       thr_limit;

  // control
  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic load_gyro, load_pid, mul_step, do_scale, out_wr;

  // loop state
  logic                    armed;
  logic [MCAND_W-1:0]      integral;
  logic signed [ERR_W-1:0] prev_err;

  // per-tick holding registers
  logic signed [STICK_W-1:0] st_roll, st_pitch, st_yaw;
  logic signed [THR_W-1:0]   thr_r;
  logic [IMAX_W-1:0]         imax;
  logic                      off_r;
  logic [OUT_W-1:0]          g_roll, g_pitch, g_yaw;
  logic [OUT_W-1:0]          roll_r, pitch_r, deriv_r, pp4, ip4;

  // input fields
  logic signed [STICK_W-1:0] in_roll, in_pitch, in_yaw, in_thr;
  logic [RATE_W-1:0] rate_roll, rate_pitch, rate_yaw, zero_roll, zero_pitch, zero_yaw;
  logic [2:0] command;

  assign in_roll    = $signed(s_tdata[11:0]);
  assign in_pitch   = $signed(s_tdata[23:12]);
  assign in_yaw     = $signed(s_tdata[35:24]);
  assign in_thr     = $signed(s_tdata[47:36]);
  assign rate_roll  = s_tdata[57:48];
  assign rate_pitch = s_tdata[67:58];
  assign rate_yaw   = s_tdata[77:68];
  assign zero_roll  = s_tdata[87:78];
  assign zero_pitch = s_tdata[97:88];
  assign zero_yaw   = s_tdata[107:98];
  assign command    = s_tdata[110:108];

  // gyro deltas: zero level minus sample
  logic signed [DELTA_W-1:0] d_roll, d_pitch, d_yaw;
  assign d_roll  = $signed({1'b0, zero_roll})  - $signed({1'b0, rate_roll});
  assign d_pitch = $signed({1'b0, zero_pitch}) - $signed({1'b0, rate_pitch});
  assign d_yaw   = $signed({1'b0, zero_yaw})   - $signed({1'b0, rate_yaw});

  // throttle rescale: (t*10) >>> 3, then cap at limit
  logic signed [15:0]      thr_x, thr_x10;
  logic signed [THR_W-1:0] thr_s, thr_cap;
  assign thr_x   = {{(16-STICK_W){in_thr[STICK_W-1]}}, in_thr};
  assign thr_x10 = (thr_x <<< 3) + (thr_x <<< 1);
  assign thr_s   = THR_W'(thr_x10 >>> 3);
  assign thr_cap = (thr_s > $signed({2'b00, thr_limit})) ? $signed({2'b00, thr_limit}) : thr_s;

  // arming: command only honored with throttle low or when disarmed
  logic arm_open, armed_new;
  always_comb begin
    arm_open  = in_thr[STICK_W-1] || !armed;
    armed_new = armed;
    if (arm_open) begin
      case (cmd_t'(command))
        CMD_ARM:    armed_new = 1'b1;
        CMD_DISARM: armed_new = 1'b0;
        default:    armed_new = armed;
      endcase
    end
  end

  // yaw error and integral step (valid in S_LOAD)
  logic signed [ERR_W-1:0] err_c;
  logic [MCAND_W-1:0]      integral_next;
  logic signed [ERR_W:0]   deriv_c;
  assign err_c = $signed({{(ERR_W-STICK_W){st_yaw[STICK_W-1]}}, st_yaw})
               - $signed({{(ERR_W-OUT_W){g_yaw[OUT_W-1]}}, g_yaw});
  assign integral_next = integral + {{(MCAND_W-ERR_W){err_c[ERR_W-1]}}, err_c};
  assign deriv_c = {err_c[ERR_W-1], err_c} - {prev_err[ERR_W-1], prev_err};

  // serial multipliers: units 0/1 do roll/pitch then P/I, unit 2 does yaw gyro
  logic signed [MCAND_W-1:0] a0, a1;
  logic [GAIN_W-1:0]         b0, b1;
  logic signed [PROD_W-1:0]  p0, p1, p2x;
  logic signed [YPROD_W-1:0] p2;

  assign a0 = load_gyro ? MCAND_W'(d_roll)  : MCAND_W'(err_c);
  assign a1 = load_gyro ? MCAND_W'(d_pitch) : $signed(integral_next);
  assign b0 = load_gyro ? rp_gain : prop_gain;
  assign b1 = load_gyro ? rp_gain : integ_gain;

  grl_mul #(.W(MCAND_W), .GW(GAIN_W)) u_mul0 (
    .clk(clk), .load(load_gyro || load_pid), .step(mul_step), .a(a0), .b(b0), .p(p0)
  );
  grl_mul #(.W(MCAND_W), .GW(GAIN_W)) u_mul1 (
    .clk(clk), .load(load_gyro || load_pid), .step(mul_step), .a(a1), .b(b1), .p(p1)
  );
  grl_mul #(.W(DELTA_W), .GW(GAIN_W)) u_mul2 (
    .clk(clk), .load(load_gyro), .step(mul_step), .a(d_yaw), .b(yaw_gain), .p(p2)
  );
  assign p2x = {{(PROD_W-YPROD_W){p2[YPROD_W-1]}}, p2};

  // PID clamps
  logic signed [PROD_W-1:0] imax_x, pp_c, ip_c, pp_sh, ip_sh;
  assign imax_x = $signed({{(PROD_W-IMAX_W){1'b0}}, imax});
  always_comb begin
    if (p0 > EMAX) begin
      pp_c = EMAX;
    end else if (p0 < -EMAX) begin
      pp_c = -EMAX;
    end else begin
      pp_c = p0;
    end
    if (p1 > imax_x) begin
      ip_c = imax_x;
    end else if (p1 < -imax_x) begin
      ip_c = -imax_x;
    end else begin
      ip_c = p1;
    end
    pp_sh = pp_c >>> PID_SHIFT;
    ip_sh = ip_c >>> PID_SHIFT;
  end

  // final yaw sum, 16-bit wrap
  logic signed [OUT_W-1:0] deriv_sh, yaw_sum;
  assign deriv_sh = $signed(deriv_r) >>> PID_SHIFT;
  assign yaw_sum  = OUT_W'(st_yaw) + $signed(pp4) + $signed(ip4) + deriv_sh;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_GYRO;
      S_GYRO:  if (cnt == '0) state_next = S_SCALE;
      S_SCALE: state_next = S_LOAD;
      S_LOAD:  state_next = S_PID;
      S_PID:   if (cnt == '0) state_next = S_CLAMP;
      S_CLAMP: state_next = S_FIN;
      S_FIN:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == S_IDLE);
    load_gyro = (state == S_IDLE) && s_tvalid;
    load_pid  = (state == S_LOAD);
    mul_step  = (state == S_GYRO) || (state == S_PID);
    do_scale  = (state == S_SCALE);
    out_wr    = (state == S_FIN) && (!m_tvalid || m_tready);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      armed      <= 1'b0;
      integral   <= '0;
      prev_err   <= '0;
      m_tvalid   <= 1'b0;
      rp_gain    <= 8'd25;
      rp_shift   <= 4'd2;
      yaw_gain   <= 8'd25;
      yaw_shift  <= 4'd2;
      prop_gain  <= 8'd25;
      integ_gain <= 8'd9;
      reverse    <= 3'd0;
      thr_limit  <= 11'd1000;
    end else begin
      state <= state_next;
      if (load_gyro || load_pid) begin
        cnt <= '1;
      end else if (mul_step) begin
        cnt <= cnt - 1'b1;
      end
      if (load_gyro) begin
        armed <= armed_new;
        if (arm_open) begin
          integral <= '0;
        end
      end
      if (load_pid) begin
        integral <= integral_next;
        prev_err <= err_c;
      end
      if (out_wr) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_RP_GAIN:    rp_gain    <= cfg_data[7:0];
          REG_RP_SHIFT:   rp_shift   <= cfg_data[3:0];
          REG_YAW_GAIN:   yaw_gain   <= cfg_data[7:0];
          REG_YAW_SHIFT:  yaw_shift  <= cfg_data[3:0];
          REG_PROP_GAIN:  prop_gain  <= cfg_data[7:0];
          REG_INTEG_GAIN: integ_gain <= cfg_data[7:0];
          REG_REVERSE:    reverse    <= cfg_data[2:0];
          REG_THR_LIMIT:  thr_limit  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_gyro) begin
      st_roll  <= in_roll;
      st_pitch <= in_pitch;
      st_yaw   <= in_yaw;
      thr_r    <= thr_cap;
      imax     <= thr_s[THR_W-1] ? '0 : thr_s[IMAX_W-1:0];
      off_r    <= in_thr[STICK_W-1] || !armed_new;
    end
    if (do_scale) begin
      g_roll  <= scale_gyro(p0,  rp_shift,  reverse[0]);
      g_pitch <= scale_gyro(p1,  rp_shift,  reverse[1]);
      g_yaw   <= scale_gyro(p2x, yaw_shift, reverse[2]);
    end
    if (load_pid) begin
      roll_r  <= OUT_W'(st_roll)  - g_roll;
      pitch_r <= OUT_W'(st_pitch) - g_pitch;
      deriv_r <= deriv_c[OUT_W-1:0];
    end
    if (state == S_CLAMP) begin
      pp4 <= pp_sh[OUT_W-1:0];
      ip4 <= ip_sh[OUT_W-1:0];
    end
    if (out_wr) begin
      m_tdata <= {2'b00, off_r, yaw_sum, pitch_r, roll_r, thr_r};
    end
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_GYRO))
    else $error("accepted tick did not start the gyro pass");

  a_arm_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready) |=> $stable(armed))
    else $error("armed flag changed without an input beat");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_FIN))
    else $error("result raised outside the final state");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !out_wr) |=> !m_tvalid)
    else $error("result beat repeated");

endmodule

/* rtl/grl_mul.sv */
// ----------------------------------------------------------------------------
// grl_mul
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain,
// one gain bit per step, LSB first.
// ----------------------------------------------------------------------------
module grl_mul #(
  parameter int W  = 32,
  parameter int GW = 8
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic signed [W-1:0]   a,
  input  logic [GW-1:0]         b,
  output logic signed [W+GW-1:0] p
);

  logic [W+GW-1:0] mcand;
  logic [GW-1:0]   mplier;
  logic [W+GW-1:0] acc;

  always_ff @(posedge clk) begin
    if (load) begin
      mcand  <= {{GW{a[W-1]}}, a};
      mplier <= b;
      acc    <= '0;
    end else if (step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[W+GW-2:0], 1'b0};
      mplier <= {1'b0, mplier[GW-1:1]};
    end
  end

  assign p = $signed(acc);

endmodule
